// ===== rtl/tlex_pkg.sv =====
package tlex_pkg;

    typedef enum logic [3:0] {
        KIND_IDENT     = 4'd0,
        KIND_NUMBER    = 4'd1,
        KIND_LET       = 4'd2,
        KIND_ASSIGN    = 4'd3,
        KIND_ADD       = 4'd4,
        KIND_SUB       = 4'd5,
        KIND_MUL       = 4'd6,
        KIND_DIV       = 4'd7,
        KIND_PRINT     = 4'd8,
        KIND_SEMICOLON = 4'd9
    } kind_t;

    localparam int PREFIX_DEPTH = 5;
    localparam int VALUE_W      = 32;
    localparam int OUT_LEN_W    = 13;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;

    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_W-1:0]    value;
        logic [OUT_LEN_W-1:0]  length;
        logic                  last;
    } token_t;

endpackage

// ===== rtl/token_lexer.sv =====
// token_lexer: byte-serial tokenizer.
// Input channel s_*: one source byte per item, with s_end_of_input marking the
// last byte of a stream. Result channel m_*: one token per item, with
// m_last_of_run set on the last token caused by a given input byte.
// An input byte yields zero, one or two tokens (a pending word, then an
// operator). Tokens are formed in the cycle the byte is accepted and written
// to a four-entry output queue; a token is presented on m_* from the queue
// once the tokens ahead of it have been taken.
// Throughput: one byte per cycle while the queue has room for two tokens;
// sustained output is one token per cycle while m_ready is high, so a byte
// that ends a word with an operator puts out two tokens, one after the other.
// Word state update (times-ten accumulate, keyword compare) is combinational.
// Reset (aresetn low, synchronous) empties the queue and clears the word
// state; s_ready is low during reset.
// When the receiver stalls, tokens collect in the queue; s_ready drops once
// fewer than two free entries remain, and no token is lost or reordered.
module token_lexer #(
    parameter int SCRATCH_CAPACITY = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_number_value,
    output logic [12:0] m_word_length,
    output logic        m_last_of_run
);
    import tlex_pkg::*;

    localparam int LEN_W   = $clog2(SCRATCH_CAPACITY + 1);
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic [LEN_W-1:0]   len_reg, len_next, len_w;
    logic               digits_reg, digits_next, digits_w;
    logic [VALUE_W-1:0] val_reg, val_next, val_w;
    logic [7:0]         prefix_reg [PREFIX_DEPTH];
    logic [7:0]         prefix_w [PREFIX_DEPTH];

    token_t             q_mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               accept, pop;
    logic               blank, is_op, delim, num_char, store;
    kind_t              op_kind, word_kind;
    logic               emit_word, is_let, is_print;
    logic [1:0]         n_push;
    token_t             tok0, tok1, word_tok, op_tok;

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;

    always_comb begin
        blank = s_char_byte inside {[CH_TAB:CH_CR], CH_SPACE};
        is_op = 1'b1;
        case (s_char_byte)
            CH_PLUS:  op_kind = KIND_ADD;
            CH_MINUS: op_kind = KIND_SUB;
            CH_STAR:  op_kind = KIND_MUL;
            CH_SLASH: op_kind = KIND_DIV;
            CH_EQUAL: op_kind = KIND_ASSIGN;
            CH_SEMI:  op_kind = KIND_SEMICOLON;
            default: begin
                op_kind = KIND_IDENT;
                is_op   = 1'b0;
            end
        endcase
        delim    = blank || is_op;
        num_char = s_char_byte inside {[CH_ZERO:CH_NINE]};
        store    = !delim && (len_reg < LEN_W'(SCRATCH_CAPACITY));
    end

    // word state after this byte is taken in (before any flush)
    always_comb begin
        len_w    = len_reg;
        digits_w = digits_reg;
        val_w    = val_reg;
        for (int i = 0; i < PREFIX_DEPTH; i++) begin
            prefix_w[i] = prefix_reg[i];
            if (store && (len_reg == LEN_W'(i))) begin
                prefix_w[i] = s_char_byte;
            end
        end
        if (store) begin
            len_w = len_reg + LEN_W'(1);
            if (num_char) begin
                val_w = (val_reg << 3) + (val_reg << 1)
                        + {{(VALUE_W-4){1'b0}}, s_char_byte[3:0]};
            end else begin
                digits_w = 1'b0;
            end
        end
    end

    always_comb begin
        is_let   = (len_w == LEN_W'(3)) && (prefix_w[0] == CH_L)
                   && (prefix_w[1] == CH_E) && (prefix_w[2] == CH_T);
        is_print = (len_w == LEN_W'(5)) && (prefix_w[0] == CH_P)
                   && (prefix_w[1] == CH_R) && (prefix_w[2] == CH_I)
                   && (prefix_w[3] == CH_N) && (prefix_w[4] == CH_T);
        if (is_let) begin
            word_kind = KIND_LET;
        end else if (is_print) begin
            word_kind = KIND_PRINT;
        end else if (digits_w) begin
            word_kind = KIND_NUMBER;
        end else begin
            word_kind = KIND_IDENT;
        end
        word_tok.kind   = word_kind;
        word_tok.value  = (word_kind == KIND_NUMBER) ? val_w : '0;
        word_tok.length = OUT_LEN_W'(len_w);
        word_tok.last   = !is_op;
        op_tok.kind     = op_kind;
        op_tok.value    = '0;
        op_tok.length   = '0;
        op_tok.last     = 1'b1;

        emit_word = (len_w != '0) && (delim || s_end_of_input);
        tok0      = emit_word ? word_tok : op_tok;
        tok1      = op_tok;
        if (emit_word && is_op) begin
            n_push = 2'd2;
        end else if (emit_word || is_op) begin
            n_push = 2'd1;
        end else begin
            n_push = 2'd0;
        end
    end

    always_comb begin
        if (!accept) begin
            len_next    = len_reg;
            digits_next = digits_reg;
            val_next    = val_reg;
        end else if (emit_word) begin
            len_next    = '0;
            digits_next = 1'b1;
            val_next    = '0;
        end else begin
            len_next    = len_w;
            digits_next = digits_w;
            val_next    = val_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            digits_reg <= 1'b1;
            val_reg    <= '0;
        end else begin
            len_reg    <= len_next;
            digits_reg <= digits_next;
            val_reg    <= val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && store) begin
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
                prefix_reg[i] <= prefix_w[i];
            end
        end
    end

    // output queue
    always_ff @(posedge aclk) begin
        if (accept && (n_push != 2'd0)) begin
            q_mem[wr_ptr_reg] <= tok0;
        end
        if (accept && (n_push == 2'd2)) begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (accept ? CNT_W'(n_push) : '0) - CNT_W'(pop);
        end
    end

    assign s_ready        = aresetn && (cnt_reg <= CNT_W'(Q_DEPTH - 2));
    assign m_valid        = (cnt_reg != '0);
    assign m_token_kind   = q_mem[rd_ptr_reg].kind;
    assign m_number_value = q_mem[rd_ptr_reg].value;
    assign m_word_length  = q_mem[rd_ptr_reg].length;
    assign m_last_of_run  = q_mem[rd_ptr_reg].last;

endmodule

// ===== tb/token_lexer_test.sv =====
`timescale 1ns / 100ps

module token_lexer_test;
    import tlex_pkg::*;

    localparam int SCRATCH_CAP  = 4096;
    localparam int RANDOM_ITEMS = 830;
    localparam int LONG_DIGITS  = 300;
    localparam int LONG_HIGH    = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [31:0] m_number_value;
    logic [12:0] m_word_length;
    logic        m_last_of_run;

    token_lexer #(
        .SCRATCH_CAPACITY(SCRATCH_CAP)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_end_of_input(s_end_of_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_number_value(m_number_value),
        .m_word_length (m_word_length),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pending word state
    int                lex_len = 0;
    bit                lex_all_digits = 1'b1;
    logic [VALUE_W-1:0] lex_value = '0;
    logic [7:0]        lex_prefix [PREFIX_DEPTH] = '{default: 8'h00};

    token_t exp_tokens[$];
    int     mismatches = 0;
    int     bytes_sent = 0;
    bit     burst_mode = 1'b0;
    int     sink_wait = 0;

    function automatic kind_t op_kind(input logic [7:0] b);
        case (b)
            CH_PLUS:  return KIND_ADD;
            CH_MINUS: return KIND_SUB;
            CH_STAR:  return KIND_MUL;
            CH_SLASH: return KIND_DIV;
            CH_EQUAL: return KIND_ASSIGN;
            CH_SEMI:  return KIND_SEMICOLON;
            default:  return KIND_IDENT;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
    endfunction

    function automatic token_t flush_word();
        token_t t;
        t.kind   = KIND_IDENT;
        t.value  = '0;
        t.length = lex_len[OUT_LEN_W-1:0];
        t.last   = 1'b0;
        if (lex_len == 3 && lex_prefix[0] == CH_L && lex_prefix[1] == CH_E
                && lex_prefix[2] == CH_T)
            t.kind = KIND_LET;
        else if (lex_len == 5 && lex_prefix[0] == CH_P && lex_prefix[1] == CH_R
                && lex_prefix[2] == CH_I && lex_prefix[3] == CH_N
                && lex_prefix[4] == CH_T)
            t.kind = KIND_PRINT;
        else if (lex_all_digits) begin
            t.kind  = KIND_NUMBER;
            t.value = lex_value;
        end
        lex_len        = 0;
        lex_all_digits = 1'b1;
        lex_value      = '0;
        return t;
    endfunction

    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        token_t toks[2];
        int     n;
        kind_t  op;
        n  = 0;
        op = op_kind(b);
        if (is_blank(b) || op != KIND_IDENT) begin
            if (lex_len != 0) begin
                toks[n] = flush_word();
                n++;
            end
            if (op != KIND_IDENT) begin
                toks[n] = '{kind: op, value: '0, length: '0, last: 1'b0};
                n++;
            end
        end else begin
            if (lex_len < SCRATCH_CAP) begin
                if (lex_len < PREFIX_DEPTH)
                    lex_prefix[lex_len] = b;
                if (b >= CH_ZERO && b <= CH_NINE)
                    lex_value = lex_value * 32'd10 + 32'(b - CH_ZERO);
                else
                    lex_all_digits = 1'b0;
                lex_len++;
            end
            if (eoi && lex_len != 0) begin
                toks[n] = flush_word();
                n++;
            end
        end
        if (n > 0)
            toks[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            exp_tokens.push_back(toks[i]);
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        s_valid        <= 1'b1;
        s_char_byte    <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(b, eoi);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string txt, input bit eoi_at_end);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], eoi_at_end && i == txt.len() - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (exp_tokens.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // sink with random backpressure
    always @(posedge aclk) begin
        if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= 1'b0;
        end else if (!burst_mode && $urandom_range(0, 9) == 0) begin
            sink_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 3);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        token_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_tokens.size() == 0) begin
                $display("%0t: unexpected token kind %0d value %0d length %0d last %0b",
                         $time, m_token_kind, m_number_value, m_word_length,
                         m_last_of_run);
                mismatches++;
            end else begin
                want = exp_tokens.pop_front();
                if (m_token_kind != want.kind) begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, m_token_kind);
                    mismatches++;
                end
                if (m_number_value != want.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.value, m_number_value);
                    mismatches++;
                end
                if (m_word_length != want.length) begin
                    $display("%0t: length expected %0d actual %0d",
                             $time, want.length, m_word_length);
                    mismatches++;
                end
                if (m_last_of_run != want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, m_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_operators();
        send_byte(CH_PLUS, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_EQUAL, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        drain();
    endtask

    task automatic test_keywords();
        // word flushed by blank, then word flushed ahead of an operator
        send_text("let print;", 1'b0);
        drain();
    endtask

    task automatic test_end_flag();
        send_text("42", 1'b1);
        send_byte(CH_SEMI, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // long number wraps its value; long high-byte word ends on the end flag
    task automatic test_long_words();
        burst_mode = 1'b1;
        for (int i = 0; i < LONG_DIGITS; i++)
            send_byte(CH_NINE, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        for (int i = 0; i < LONG_HIGH; i++)
            send_byte(8'h80 + 8'(i % 128), i == LONG_HIGH - 1);
        burst_mode = 1'b0;
        drain();
    endtask

    task automatic send_noisy(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 24) == 0);
    endtask

    task automatic test_random_stream();
        string       kw_words[10];
        logic [7:0]  ops[6];
        logic [7:0]  blanks[6];
        int          start;
        int          r;
        int          len;
        bit          paused;
        kw_words = '{"let", "print", "le", "lett", "prin", "printt", "pr1nt", "Let",
                     "lex", "p"};
        ops      = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL, CH_SEMI};
        blanks   = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        start    = bytes_sent;
        paused   = 1'b0;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                burst_mode = ~burst_mode;
            if (!paused && bytes_sent - start >= RANDOM_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                len = $urandom_range(0, 9);
                for (int i = 0; i < kw_words[len].len(); i++)
                    send_noisy(kw_words[len][i]);
            end else if (r < 40) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_noisy(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (r < 55) begin
                len = $urandom_range(1, 8);
                send_noisy(8'h61 + 8'($urandom_range(0, 25)));
                for (int i = 1; i < len; i++)
                    case ($urandom_range(0, 2))
                        0: send_noisy(8'h61 + 8'($urandom_range(0, 25)));
                        1: send_noisy(CH_ZERO + 8'($urandom_range(0, 9)));
                        default: send_noisy(8'($urandom_range(128, 255)));
                    endcase
            end else if (r < 75) begin
                send_noisy(ops[$urandom_range(0, 5)]);
            end else if (r < 88) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_noisy(blanks[$urandom_range(0, 5)]);
            end else begin
                send_noisy(8'($urandom_range(0, 255)));
            end
        end
        burst_mode = 1'b0;
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_keywords();
        test_end_flag();
        test_long_words();
        test_random_stream();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && exp_tokens.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== token_lexer.f =====
rtl/tlex_pkg.sv
rtl/token_lexer.sv
tb/token_lexer_test.sv
